// ===== sv/frame_delta_run_encoder_defines.svh =====
// Assertion macros for the frame delta run encoder.
`ifndef FRAME_DELTA_RUN_ENCODER_DEFINES_SVH
`define FRAME_DELTA_RUN_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define FDRE_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define FDRE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define FDRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FDRE_ASSERT(lbl, cond, msg)
`define FDRE_ASSERT_IMPL(lbl, ante, cons, msg)
`define FDRE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/fdre_pkg.sv =====
// Shared types and constants of the frame delta run encoder.
package fdre_pkg;

	localparam int MAX_FRAME_WORDS_DEF = 65536;
	localparam int WORD_W              = 32;
	localparam int FRAME_WORDS_W       = 17;
	localparam int WORD_BYTES          = 4;
	localparam int RUN_HEADER_BYTES    = 8;
	localparam int NUM_KINDS           = 4;
	localparam logic [FRAME_WORDS_W-1:0] FRAME_WORDS_RST = 17'h10000;

	typedef enum logic [1:0] {
		KIND_OFFSET = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_LENGTH = 2'd2,
		KIND_TOTAL  = 2'd3
	} fdre_kind_t;

	// Results of one item: mask bit i set means a result of kind i, emitted in kind order
	typedef struct packed {
		logic [NUM_KINDS-1:0]             mask;
		logic [NUM_KINDS-1:0][WORD_W-1:0] val;
	} fdre_bundle_t;

endpackage

// ===== sv/fdre_ref_mem.sv =====
// Reference frame store: synchronous RAM with fill count and write-to-read forwarding.
module fdre_ref_mem #(
	parameter int DEPTH = fdre_pkg::MAX_FRAME_WORDS_DEF,
	parameter int AW    = $clog2(fdre_pkg::MAX_FRAME_WORDS_DEF)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [fdre_pkg::WORD_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [fdre_pkg::WORD_W-1:0] wr_data
);
	import fdre_pkg::*;

	`include "frame_delta_run_encoder_defines.svh"

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic [WORD_W-1:0] fdata_q;
	logic              hit_q;
	logic              inb_q;
	// entries below fill_q have been written; the rest still read as zero
	logic [AW:0]       fill_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
			fdata_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			inb_q  <= 1'b0;
			fill_q <= '0;
		end else begin
			if (rd_en) begin
				// a write on the same edge is not yet visible in the array
				hit_q <= wr_en && (wr_addr == rd_addr);
				inb_q <= {1'b0, rd_addr} < fill_q;
			end
			if (wr_en && ({1'b0, wr_addr} == fill_q)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign rd_data = hit_q ? fdata_q : (inb_q ? rdata_q : '0);

	`FDRE_ASSERT(a_fill_range, fill_q <= (AW+1)'(DEPTH), "fill count beyond depth")
	`FDRE_ASSERT_IMPL(a_wr_prefix, wr_en, {1'b0, wr_addr} <= fill_q, "write skips past fill count")

endmodule

// ===== sv/fdre_emit.sv =====
// Result serializer: holds one item's results and sends them one per cycle while out_stall is low.
module fdre_emit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  fdre_pkg::fdre_bundle_t bundle,
	output logic                   free,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             kind,
	output logic [fdre_pkg::WORD_W-1:0] value,
	output logic                   last
);
	import fdre_pkg::*;

	`include "frame_delta_run_encoder_defines.svh"

	logic [NUM_KINDS-1:0]             mask_q;
	logic [NUM_KINDS-1:0][WORD_W-1:0] val_q;
	fdre_kind_t                       idx;
	logic                             out_acc;
	logic                             fill_new;

	always_comb begin
		priority if (mask_q[KIND_OFFSET]) begin
			idx = KIND_OFFSET;
		end else if (mask_q[KIND_DATA]) begin
			idx = KIND_DATA;
		end else if (mask_q[KIND_LENGTH]) begin
			idx = KIND_LENGTH;
		end else begin
			idx = KIND_TOTAL;
		end
	end

	assign out_valid = |mask_q;
	assign last      = (mask_q & (mask_q - 1'b1)) == '0;
	assign kind      = idx;
	assign value     = val_q[idx];
	assign out_acc   = out_valid && !out_stall;
	assign free      = !out_valid || (last && !out_stall);
	assign fill_new  = load && (|bundle.mask);

	always_ff @(posedge clk) begin
		if (fill_new) begin
			val_q <= bundle.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (fill_new) begin
			mask_q <= bundle.mask;
		end else if (out_acc) begin
			// drop the result just taken
			mask_q <= mask_q & (mask_q - 1'b1);
		end
	end

	`FDRE_ASSERT_IMPL(a_load_free, fill_new, free, "results loaded over pending ones")
	`FDRE_ASSERT_NEXT(a_drain, out_acc && last && !fill_new, !out_valid, "result repeated after last")

endmodule

// ===== sv/frame_delta_run_encoder.sv =====
// Frame delta run encoder top level: position, compare stage and run bookkeeping.
// An accepted item is registered into the compare stage, then loaded into the result serializer.
// Throughput: one item per cycle while each item yields at most one result and out_stall is low;
// an item with several results holds the single result port until all are sent, and input stalls behind it.
// Reset: position, run and byte counts clear, frame_words returns to 65536, and the
// reference store reads as all zero through its fill count, so no clearing pass is run.
module frame_delta_run_encoder #(
	parameter int MAX_FRAME_WORDS = fdre_pkg::MAX_FRAME_WORDS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fdre_pkg::FRAME_WORDS_W-1:0] frame_words,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [fdre_pkg::WORD_W-1:0]        new_word,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         kind,
	output logic [fdre_pkg::WORD_W-1:0]        value,
	output logic                               last
);
	import fdre_pkg::*;

	`include "frame_delta_run_encoder_defines.svh"

	localparam int AW  = $clog2(MAX_FRAME_WORDS);
	localparam int LW  = (AW + 1 > FRAME_WORDS_W) ? AW + 1 : FRAME_WORDS_W;
	localparam int RBW = AW + 3;
	localparam int TW  = AW + 4;

	logic [FRAME_WORDS_W-1:0] frame_words_q;
	logic [AW-1:0]            pos_q;
	logic                     run_open_q;
	logic [RBW-1:0]           run_bytes_q;
	logic [TW-1:0]            total_q;

	logic                     valid_s1;
	logic [WORD_W-1:0]        word_s1;
	logic [AW-1:0]            addr_s1;
	logic                     end_s1;

	logic [LW-1:0]            fw_ext;
	logic [LW-1:0]            limit;
	logic [LW-1:0]            pos_ext;
	logic [LW-1:0]            pos_c;
	logic                     frame_end;
	logic                     accept_in;
	logic                     retire;
	logic [WORD_W-1:0]        ref_word;
	logic                     changed;
	logic [RBW-1:0]           run_bytes_new;
	logic [TW-1:0]            total_new;
	fdre_bundle_t             bundle;
	logic                     emit_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_words_q <= FRAME_WORDS_RST;
		end else if (cfg_valid && cfg_ready) begin
			frame_words_q <= frame_words;
		end
	end

	// frame length clamped to 1..MAX_FRAME_WORDS, position clamped to the last word
	always_comb begin
		fw_ext  = LW'(frame_words_q);
		pos_ext = LW'(pos_q);
		if (fw_ext == '0) begin
			limit = LW'(1);
		end else if (fw_ext > LW'(MAX_FRAME_WORDS)) begin
			limit = LW'(MAX_FRAME_WORDS);
		end else begin
			limit = fw_ext;
		end
		pos_c     = (pos_ext >= limit) ? limit - 1'b1 : pos_ext;
		frame_end = (pos_c + 1'b1) >= limit;
	end

	assign retire    = valid_s1 && ((bundle.mask == '0) || emit_free);
	assign in_stall  = valid_s1 && !retire;
	assign accept_in = in_valid && !in_stall;

	fdre_ref_mem #(
		.DEPTH(MAX_FRAME_WORDS),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept_in),
		.rd_addr(pos_c[AW-1:0]),
		.rd_data(ref_word),
		.wr_en  (retire),
		.wr_addr(addr_s1),
		.wr_data(word_s1)
	);

	always_ff @(posedge clk) begin
		if (accept_in) begin
			word_s1 <= new_word;
			addr_s1 <= pos_c[AW-1:0];
			end_s1  <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (accept_in) begin
				valid_s1 <= 1'b1;
				pos_q    <= frame_end ? '0 : AW'(pos_c + 1'b1);
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// compare against the reference and build this item's results
	always_comb begin
		changed       = ref_word != word_s1;
		run_bytes_new = run_bytes_q;
		total_new     = total_q;
		if (changed) begin
			run_bytes_new = (run_open_q ? run_bytes_q : '0) + RBW'(WORD_BYTES);
			total_new     = total_q + (run_open_q ? TW'(WORD_BYTES)
			                                      : TW'(WORD_BYTES + RUN_HEADER_BYTES));
		end
		bundle.mask[KIND_OFFSET] = changed && !run_open_q;
		bundle.mask[KIND_DATA]   = changed;
		bundle.mask[KIND_LENGTH] = (!changed && run_open_q) || (end_s1 && changed);
		bundle.mask[KIND_TOTAL]  = end_s1;
		bundle.val[KIND_OFFSET]  = WORD_W'(addr_s1) << 2;
		bundle.val[KIND_DATA]    = word_s1;
		bundle.val[KIND_LENGTH]  = WORD_W'(run_bytes_new);
		bundle.val[KIND_TOTAL]   = WORD_W'(total_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q  <= 1'b0;
			run_bytes_q <= '0;
			total_q     <= '0;
		end else if (retire) begin
			run_open_q  <= changed && !end_s1;
			run_bytes_q <= end_s1 ? '0 : run_bytes_new;
			total_q     <= end_s1 ? '0 : total_new;
		end
	end

	fdre_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (retire),
		.bundle   (bundle),
		.free     (emit_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind     (kind),
		.value    (value),
		.last     (last)
	);

	`FDRE_ASSERT_IMPL(a_no_overrun, accept_in && valid_s1, retire, "compare stage overwritten")
	`FDRE_ASSERT_NEXT(a_frame_restart, retire && end_s1,
		total_q == '0 && !run_open_q, "frame end did not restart state")

endmodule

// ===== test/frame_delta_run_encoder_tb.sv =====
// Self-checking testbench for the frame delta run encoder.
`timescale 1ns / 100ps

module frame_delta_run_encoder_tb;
	import fdre_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_WORDS  = 170;
	localparam int HOLD_CYCLES   = 200;

	typedef struct {
		fdre_kind_t            kind;
		logic [WORD_W-1:0]     value;
		logic                  last;
	} enc_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [FRAME_WORDS_W-1:0] frame_words;
	logic                     in_valid;
	logic                     in_stall;
	logic [WORD_W-1:0]        new_word;
	logic                     out_valid;
	logic                     out_stall;
	logic [1:0]               kind;
	logic [WORD_W-1:0]        value;
	logic                     last;

	// predictor state
	bit [WORD_W-1:0]          ref_frame [MAX_FRAME_WORDS_DEF];
	logic [FRAME_WORDS_W-1:0] cfg_words = FRAME_WORDS_RST;
	int                       word_pos = 0;
	bit                       run_open = 1'b0;
	logic [18:0]              run_bytes = '0;
	logic [19:0]              total_bytes = '0;

	enc_result_t              expected_q[$];
	int                       error_count = 0;
	int                       cycle_count = 0;
	int                       words_sent = 0;
	int                       hold_left = 0;
	bit                       no_idle = 1'b0;

	frame_delta_run_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.frame_words(frame_words),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.new_word   (new_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.value      (value),
		.last       (last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int frame_limit();
		int lim;
		lim = cfg_words;
		if (lim == 0)
			lim = 1;
		if (lim > MAX_FRAME_WORDS_DEF)
			lim = MAX_FRAME_WORDS_DEF;
		return lim;
	endfunction

	function automatic int current_pos();
		int lim;
		lim = frame_limit();
		return (word_pos >= lim) ? lim - 1 : word_pos;
	endfunction

	// work out the results one accepted word causes
	task automatic predict_word(input logic [WORD_W-1:0] w);
		int  pos;
		bit  at_end;
		int  first;
		pos = current_pos();
		at_end = (pos + 1 >= frame_limit());
		first = expected_q.size();
		if (ref_frame[pos] != w) begin
			ref_frame[pos] = w;
			if (!run_open) begin
				run_open = 1'b1;
				run_bytes = '0;
				total_bytes += RUN_HEADER_BYTES;
				expected_q.push_back('{KIND_OFFSET, WORD_W'(pos * WORD_BYTES), 1'b0});
			end
			run_bytes += WORD_BYTES;
			total_bytes += WORD_BYTES;
			expected_q.push_back('{KIND_DATA, w, 1'b0});
		end else if (run_open) begin
			run_open = 1'b0;
			expected_q.push_back('{KIND_LENGTH, WORD_W'(run_bytes), 1'b0});
		end
		if (at_end) begin
			if (run_open) begin
				run_open = 1'b0;
				expected_q.push_back('{KIND_LENGTH, WORD_W'(run_bytes), 1'b0});
			end
			expected_q.push_back('{KIND_TOTAL, WORD_W'(total_bytes), 1'b0});
			word_pos = 0;
			run_bytes = '0;
			total_bytes = '0;
		end else begin
			word_pos = pos + 1;
		end
		if (expected_q.size() > first)
			expected_q[$].last = 1'b1;
	endtask

	// changed or unchanged word for the next position
	function automatic logic [WORD_W-1:0] pick_word(input bit keep);
		logic [WORD_W-1:0] cur;
		cur = ref_frame[current_pos()];
		if (keep)
			return cur;
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return cur ^ (32'd1 << $urandom_range(31));
			default: return $urandom();
		endcase
	endfunction

	// entered and left at a falling edge; valid stays up for a following item
	task automatic send_word(input logic [WORD_W-1:0] w);
		if (!no_idle) begin
			while ($urandom_range(99) < 26) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		new_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_frame_words(input logic [FRAME_WORDS_W-1:0] v);
		in_valid <= 1'b0;
		wait_drained();
		// words with no result may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		frame_words <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_words = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < 26);
			end
		end
	end

	always @(posedge clk) begin : check_results
		enc_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected item kind %0d value %h", kind, value));
			end else begin
				want = expected_q.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
				if (value !== want.value)
					report_mismatch($sformatf("value %h, want %h (kind %0d)",
						value, want.value, want.kind));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, want %b (kind %0d)",
						last, want.last, want.kind));
			end
		end
	end

	// runs opening and closing inside the reset-length frame
	task automatic test_run_open_close();
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFFF);
		send_word(32'h8000_0001);
		send_word(32'h0000_0000);
		send_word(32'h0000_0001);
		send_word(32'h0000_0000);
	endtask

	// zero, one, above-max and a shrink below the current position
	task automatic test_frame_length_limits();
		write_frame_words('0);
		send_word(32'h1234_5678);
		send_word(32'h1234_5678);
		write_frame_words(FRAME_WORDS_W'(1));
		send_word(32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF);
		write_frame_words('1);
		send_word(32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF);
		send_word(32'h7FFF_FFFE);
		send_word(32'hA5A5_A5A5);
		write_frame_words(FRAME_WORDS_W'(3));
		send_word(32'h7FFF_FFFE);
		send_word(32'h5A5A_5A5A);
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFFF);
		write_frame_words(FRAME_WORDS_RST);
	endtask

	task automatic test_random_frames();
		int  n;
		int  sel;
		bit  changing;
		bit  quiet_done;
		changing = 1'b0;
		quiet_done = 1'b0;
		while (words_sent < RANDOM_WORDS) begin
			sel = $urandom_range(99);
			if (sel < 70)
				write_frame_words(FRAME_WORDS_W'($urandom_range(1, 12)));
			else if (sel < 90)
				write_frame_words(FRAME_WORDS_W'($urandom_range(13, 40)));
			else
				write_frame_words('0);
			// one stretch with both sides always ready
			if (!quiet_done && words_sent > RANDOM_WORDS / 2) begin
				no_idle = 1'b1;
				quiet_done = 1'b1;
			end
			n = $urandom_range(8, 30);
			repeat (n) begin
				if ($urandom_range(99) < 35)
					changing = !changing;
				send_word(pick_word(!changing));
			end
			no_idle = 1'b0;
		end
	endtask

	// receiver holds off while words keep coming, so the input backs up
	task automatic test_output_backpressure();
		write_frame_words(FRAME_WORDS_W'(5));
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		@(negedge clk);
		repeat (40)
			send_word(pick_word($urandom_range(99) < 30));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		frame_words = '0;
		in_valid = 1'b0;
		new_word = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_run_open_close();
		test_frame_length_limits();
		test_random_frames();
		test_output_backpressure();

		in_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (expected_q.size() != 0)
			report_mismatch($sformatf("%0d items never arrived", expected_q.size()));
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
